// ===== hw/rtl/ultrasonic_echo_ranger_core_defines.svh =====
// Assertion macros for the echo ranger checker
`ifndef ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk_i and held off during reset
`define UER_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("echo ranger: same-cycle check failed");

// next-cycle implication, sampled on clk_i and held off during reset
`define UER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("echo ranger: next-cycle check failed");

`endif

// ===== hw/rtl/uer_pkg.sv =====
// Shared types and constants of the echo ranger
`timescale 1ns / 1ps
package uer_pkg;

  localparam int unsigned MAX_LANES  = 4;
  localparam int unsigned WIDTH_W    = 10;
  localparam int unsigned LOW_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 3;

  localparam logic [LOW_W-1:0]   PERIOD_RST = 16'd1000;
  localparam logic [LOW_W-1:0]   LOW_MAX    = 16'hFFFF;
  localparam logic [WIDTH_W-1:0] WIDTH_RST  = 10'd600;
  localparam logic [COUNT_W-1:0] COUNT_RST  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0 = 3'd2;

  typedef struct packed {
    logic [MAX_LANES-1:0] echo_levels;
  } in_item_t;

  typedef struct packed {
    logic [MAX_LANES-1:0] trigger_mask;
    logic [MAX_LANES-1:0] latched_mask;
    logic [WIDTH_W-1:0]   width_0;
    logic [WIDTH_W-1:0]   width_1;
    logic [WIDTH_W-1:0]   width_2;
    logic [WIDTH_W-1:0]   width_3;
  } out_item_t;

  typedef struct packed {
    logic             step;
    logic             clear;
    logic             level;
    logic [LOW_W-1:0] period;
  } lane_ctl_t;

  typedef struct packed {
    logic               latched;
    logic [WIDTH_W-1:0] width;
  } lane_res_t;

endpackage

// ===== hw/rtl/uer_stream_if.sv =====
// Valid/ready stream interface carrying one request payload
`timescale 1ns / 1ps
interface uer_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/uer_lane.sv =====
// One sensor lane: high and low tick counters, edge detect and width latch
`timescale 1ns / 1ps
module uer_lane #(
  parameter int unsigned HIGH_LIMIT = 600
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uer_pkg::lane_ctl_t ctl_i,
  output logic              cand_o,
  input  logic              grant_i,
  output uer_pkg::lane_res_t res_o
);

  localparam int unsigned HiW = uer_pkg::WIDTH_W + 1;
  localparam logic [HiW-1:0] LimitExt = HiW'(HIGH_LIMIT);

  logic                       level_q, level_d;
  logic [uer_pkg::WIDTH_W-1:0] high_q, high_d;
  logic [uer_pkg::LOW_W-1:0]   low_q, low_d;
  logic [uer_pkg::WIDTH_W-1:0] width_q, width_d;
  logic [HiW-1:0]              hi_inc;
  logic [uer_pkg::LOW_W-1:0]   lo_inc;
  logic [uer_pkg::WIDTH_W-1:0] hi_sat;
  logic                        flag;

  always_comb begin
    hi_inc = {1'b0, high_q} + HiW'(ctl_i.level);
    lo_inc = (!ctl_i.level && (low_q != uer_pkg::LOW_MAX)) ? low_q + 16'd1 : low_q;
    cand_o = ctl_i.step && (lo_inc > ctl_i.period);

    level_d = level_q;
    high_d  = high_q;
    low_d   = low_q;
    width_d = width_q;
    flag    = 1'b0;
    hi_sat  = hi_inc[uer_pkg::WIDTH_W-1:0];

    if (ctl_i.clear) begin
      level_d = 1'b0;
      high_d  = '0;
      low_d   = ctl_i.period;
    end else if (ctl_i.step) begin
      low_d = grant_i ? '0 : lo_inc;
      if (hi_inc > LimitExt) begin
        hi_sat  = LimitExt[uer_pkg::WIDTH_W-1:0];
        width_d = LimitExt[uer_pkg::WIDTH_W-1:0];
        flag    = 1'b1;
      end
      high_d = hi_sat;
      if (level_q != ctl_i.level) begin
        if (ctl_i.level) begin
          high_d = 10'd1;
          low_d  = '0;
        end else begin
          width_d = hi_sat;
          low_d   = 16'd1;
          flag    = 1'b1;
        end
      end
      level_d = ctl_i.level;
    end

    res_o.latched = flag;
    res_o.width   = width_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      high_q  <= '0;
      low_q   <= uer_pkg::PERIOD_RST;
      width_q <= uer_pkg::WIDTH_RST;
    end else begin
      level_q <= level_d;
      high_q  <= high_d;
      low_q   <= low_d;
      width_q <= width_d;
    end
  end

endmodule

// ===== hw/rtl/uer_merge.sv =====
// Merge stage: trigger arbitration across lanes and result assembly
`timescale 1ns / 1ps
module uer_merge #(
  parameter int unsigned NUM_LANES = 4
) (
  input  logic [NUM_LANES-1:0] cand_i,
  output logic [NUM_LANES-1:0] grant_o,
  input  uer_pkg::lane_res_t   res_i [NUM_LANES],
  output uer_pkg::out_item_t   item_o
);

  logic                                               taken;
  logic [uer_pkg::MAX_LANES-1:0]                      trig;
  logic [uer_pkg::MAX_LANES-1:0]                      lat;
  logic [uer_pkg::MAX_LANES-1:0][uer_pkg::WIDTH_W-1:0] widths;

  // highest-numbered candidate wins
  always_comb begin
    taken = 1'b0;
    for (int j = NUM_LANES - 1; j >= 0; j--) begin
      grant_o[j] = cand_i[j] && !taken;
      taken      = taken || cand_i[j];
    end
  end

  always_comb begin
    trig   = '0;
    lat    = '0;
    widths = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      trig[j]   = grant_o[j];
      lat[j]    = res_i[j].latched;
      widths[j] = res_i[j].width;
    end
    item_o.trigger_mask = trig;
    item_o.latched_mask = lat;
    item_o.width_0      = widths[0];
    item_o.width_1      = widths[1];
    item_o.width_2      = widths[2];
    item_o.width_3      = widths[3];
  end

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger_core.sv =====
// Echo ranger top level: configuration, sensor lanes, merge and output buffering
// A result is registered into the output register, or into the skid register while the output stalls.
// Throughput: one tick per cycle while the skid register is empty; the enabled lanes update in parallel.
// An output register plus one skid register keep the input open while one result waits.
// Reset: enable mask 0, sensor count 4, periods 1000, low counts 1000, widths 600.
`timescale 1ns / 1ps
module ultrasonic_echo_ranger_core #(
  parameter int unsigned SENSOR_LANES = 4,
  parameter int unsigned HIGH_LIMIT   = 600
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  uer_stream_if.sink                       echo_i,
  uer_stream_if.source                     result_o
);

  localparam int unsigned NumLanes =
    (SENSOR_LANES < uer_pkg::MAX_LANES) ? SENSOR_LANES : uer_pkg::MAX_LANES;

  logic [uer_pkg::MAX_LANES-1:0] enable_q;
  logic [uer_pkg::COUNT_W-1:0]   count_q;
  logic [uer_pkg::LOW_W-1:0]     period_q [NumLanes];
  logic [uer_pkg::MAX_LANES-1:0] clear_vec;

  uer_pkg::lane_ctl_t ctl [NumLanes];
  uer_pkg::lane_res_t res [NumLanes];
  logic [NumLanes-1:0] cand;
  logic [NumLanes-1:0] grant;
  uer_pkg::out_item_t  item;

  uer_pkg::out_item_t out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               in_fire, out_fire;

  assign in_fire  = echo_i.valid && echo_i.ready;
  assign out_fire = out_valid_q && result_o.ready;

  assign clear_vec = (cfg_we_i && (cfg_idx_i == uer_pkg::REG_ENABLE))
                   ? (cfg_wdata_i[uer_pkg::MAX_LANES-1:0] ^ enable_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      count_q  <= uer_pkg::COUNT_RST;
      for (int i = 0; i < NumLanes; i++) begin
        period_q[i] <= uer_pkg::PERIOD_RST;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == uer_pkg::REG_ENABLE) begin
        enable_q <= cfg_wdata_i[uer_pkg::MAX_LANES-1:0];
      end
      if (cfg_idx_i == uer_pkg::REG_COUNT) begin
        count_q <= cfg_wdata_i[uer_pkg::COUNT_W-1:0];
      end
      for (int i = 0; i < NumLanes; i++) begin
        if (cfg_idx_i == uer_pkg::REG_PERIOD_0 + uer_pkg::CFG_IDX_W'(i)) begin
          period_q[i] <= cfg_wdata_i[uer_pkg::LOW_W-1:0];
        end
      end
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    assign ctl[g].step   = in_fire && enable_q[g] && (uer_pkg::COUNT_W'(g) < count_q);
    assign ctl[g].clear  = clear_vec[g];
    assign ctl[g].level  = echo_i.payload.echo_levels[g];
    assign ctl[g].period = period_q[g];

    uer_lane #(
      .HIGH_LIMIT(HIGH_LIMIT)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[g]),
      .cand_o (cand[g]),
      .grant_i(grant[g]),
      .res_o  (res[g])
    );
  end

  uer_merge #(
    .NUM_LANES(NumLanes)
  ) u_merge (
    .cand_i (cand),
    .grant_o(grant),
    .res_i  (res),
    .item_o (item)
  );

  // output register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= item;
      end else begin
        skid_q <= item;
      end
    end
  end

  assign echo_i.ready     = !skid_valid_q;
  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

// ===== hw/rtl/uer_checker.sv =====
// Port-level checks for the echo ranger top level and their bind
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_core_defines.svh"
module uer_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [uer_pkg::MAX_LANES-1:0] trigger_mask_i,
  input uer_pkg::out_item_t            out_payload_i
);

  `UER_ASSERT_IMPLY(a_one_trigger, out_valid_i, $onehot0(trigger_mask_i))
  `UER_ASSERT_NEXT(a_accept_gives_result, in_valid_i && in_ready_i && !out_valid_i, out_valid_i)
  `UER_ASSERT_IMPLY(a_stall_only_when_full, !in_ready_i, out_valid_i)
  `UER_ASSERT_NEXT(a_stalled_result_holds, out_valid_i && !out_ready_i, $stable(out_payload_i))

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (echo_i.valid),
  .in_ready_i    (echo_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .trigger_mask_i(result_o.payload.trigger_mask),
  .out_payload_i (result_o.payload)
);

// ===== sim/tb_ultrasonic_echo_ranger_core.sv =====
// Self-checking testbench for the echo ranger core: directed and random tick streams
`timescale 1ns / 1ps
module tb_ultrasonic_echo_ranger_core;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [uer_pkg::WIDTH_W-1:0] PULSE_CAP = 10'd600;
  localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [uer_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           cfg_we = 1'b0;
  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                          echo_valid = 1'b0;
  logic [uer_pkg::MAX_LANES-1:0] echo_levels = '0;
  logic                          result_ready = 1'b0;

  uer_stream_if #(.payload_t(uer_pkg::in_item_t))  echo_if ();
  uer_stream_if #(.payload_t(uer_pkg::out_item_t)) result_if ();

  assign echo_if.valid   = echo_valid;
  assign echo_if.payload = uer_pkg::in_item_t'(echo_levels);
  assign result_if.ready = result_ready;

  ultrasonic_echo_ranger_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .echo_i     (echo_if),
    .result_o   (result_if)
  );

  logic [uer_pkg::MAX_LANES-1:0] ctl_enable = '0;
  logic [uer_pkg::COUNT_W-1:0]   ctl_count = uer_pkg::COUNT_RST;
  logic [uer_pkg::LOW_W-1:0]     ctl_period [uer_pkg::MAX_LANES] =
                                   '{default: uer_pkg::PERIOD_RST};
  logic                          lane_prev [uer_pkg::MAX_LANES] = '{default: 1'b0};
  logic [uer_pkg::WIDTH_W-1:0]   lane_high [uer_pkg::MAX_LANES] = '{default: '0};
  logic [uer_pkg::LOW_W-1:0]     lane_low [uer_pkg::MAX_LANES] =
                                   '{default: uer_pkg::PERIOD_RST};
  logic [uer_pkg::WIDTH_W-1:0]   lane_width [uer_pkg::MAX_LANES] =
                                   '{default: uer_pkg::WIDTH_RST};

  int   run_left [uer_pkg::MAX_LANES] = '{default: 0};
  logic run_level [uer_pkg::MAX_LANES] = '{default: 1'b0};

  logic [uer_pkg::MAX_LANES-1:0] pending_ticks[$];
  uer_pkg::out_item_t            expected_readings[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_checked = 0;
  int unsigned trigger_count = 0;
  int unsigned latch_count = 0;
  int unsigned settings_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic uer_pkg::out_item_t predict_tick(logic [uer_pkg::MAX_LANES-1:0] levels);
    uer_pkg::out_item_t r;
    int                 scan;
    bit                 fired;
    logic               lvl;
    r = '0;
    fired = 1'b0;
    scan = (ctl_count > uer_pkg::MAX_LANES) ? uer_pkg::MAX_LANES : ctl_count;
    for (int i = scan - 1; i >= 0; i--) begin
      if (!ctl_enable[i]) continue;
      lvl = levels[i];
      if (lvl) lane_high[i]++;
      else if (lane_low[i] != uer_pkg::LOW_MAX) lane_low[i]++;
      if (lane_low[i] > ctl_period[i] && !fired) begin
        lane_low[i] = '0;
        fired = 1'b1;
        r.trigger_mask[i] = 1'b1;
      end
      if (lane_high[i] > PULSE_CAP) begin
        lane_high[i] = PULSE_CAP;
        lane_width[i] = PULSE_CAP;
        r.latched_mask[i] = 1'b1;
      end
      if (lane_prev[i] != lvl) begin
        if (lvl) begin
          lane_high[i] = 10'd1;
          lane_low[i] = '0;
        end else begin
          lane_width[i] = lane_high[i];
          lane_low[i] = 16'd1;
          r.latched_mask[i] = 1'b1;
        end
      end
      lane_prev[i] = lvl;
    end
    r.width_0 = lane_width[0];
    r.width_1 = lane_width[1];
    r.width_2 = lane_width[2];
    r.width_3 = lane_width[3];
    return r;
  endfunction

  // Echo pulses with random widths, long ones now and then, plus some noise on short runs
  function automatic logic [uer_pkg::MAX_LANES-1:0] next_levels();
    logic [uer_pkg::MAX_LANES-1:0] lv;
    logic [uer_pkg::MAX_LANES-1:0] calm;
    for (int i = 0; i < uer_pkg::MAX_LANES; i++) begin
      if (run_left[i] == 0) begin
        run_level[i] = !run_level[i];
        if (run_level[i])
          run_left[i] = ($urandom_range(19) == 0) ? $urandom_range(606, 597)
                                                   : $urandom_range(25, 1);
        else
          run_left[i] = $urandom_range(40, 1);
      end
      run_left[i]--;
      lv[i] = run_level[i];
      calm[i] = run_left[i] < 60;
    end
    if ($urandom_range(9) == 0) lv ^= 4'($urandom) & calm;
    return lv;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uer_pkg::CFG_DATA_W-1:0] data);
    logic [uer_pkg::MAX_LANES-1:0] changed;
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    if (idx == uer_pkg::REG_ENABLE) begin
      changed = data[uer_pkg::MAX_LANES-1:0] ^ ctl_enable;
      for (int i = 0; i < uer_pkg::MAX_LANES; i++) begin
        if (changed[i]) begin
          lane_prev[i] = 1'b0;
          lane_high[i] = '0;
          lane_low[i] = ctl_period[i];
        end
      end
      ctl_enable = data[uer_pkg::MAX_LANES-1:0];
    end else if (idx == uer_pkg::REG_COUNT) begin
      ctl_count = data[uer_pkg::COUNT_W-1:0];
    end else if (idx >= uer_pkg::REG_PERIOD_0 &&
                 idx < uer_pkg::REG_PERIOD_0 + uer_pkg::MAX_LANES) begin
      ctl_period[idx - uer_pkg::REG_PERIOD_0] = data;
    end
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  task automatic configure(input logic [uer_pkg::MAX_LANES-1:0] enable,
                           input logic [uer_pkg::COUNT_W-1:0] count,
                           input int unsigned lo, input int unsigned hi);
    for (int i = 0; i < uer_pkg::MAX_LANES; i++)
      write_reg(uer_pkg::CFG_IDX_W'(uer_pkg::REG_PERIOD_0 + i), 16'($urandom_range(hi, lo)));
    write_reg(uer_pkg::REG_COUNT, {13'($urandom), count});
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
    write_reg(uer_pkg::REG_ENABLE, {12'($urandom), enable});
    finish_writes();
  endtask

  task automatic queue_ticks(input int unsigned count);
    for (int n = 0; n < count; n++) pending_ticks.push_back(next_levels());
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || echo_valid || expected_readings.size() != 0)
      @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!echo_valid || echo_if.ready) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
        echo_valid <= 1'b1;
        echo_levels <= pending_ticks.pop_front();
      end else begin
        echo_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 60;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    uer_pkg::out_item_t want;
    uer_pkg::out_item_t got;
    if (rst_n) begin
      if (result_if.valid && result_if.ready) begin
        got = result_if.payload;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          check_field("trigger_mask", want.trigger_mask, got.trigger_mask);
          check_field("latched_mask", want.latched_mask, got.latched_mask);
          check_field("width_0", want.width_0, got.width_0);
          check_field("width_1", want.width_1, got.width_1);
          check_field("width_2", want.width_2, got.width_2);
          check_field("width_3", want.width_3, got.width_3);
          ticks_checked++;
          trigger_count += $countones(want.trigger_mask);
          latch_count += $countones(want.latched_mask);
        end
      end
      if (echo_if.valid && echo_if.ready)
        expected_readings.push_back(predict_tick(echo_if.payload.echo_levels));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, expected_readings.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    pending_ticks = {4'hF, 4'h0};
    drain();

    write_reg(uer_pkg::REG_PERIOD_0, 16'h0000);
    write_reg(uer_pkg::CFG_IDX_W'(uer_pkg::REG_PERIOD_0 + 1), 16'hFFFE);
    write_reg(uer_pkg::CFG_IDX_W'(uer_pkg::REG_PERIOD_0 + 2), 16'hFFFF);
    write_reg(uer_pkg::CFG_IDX_W'(uer_pkg::REG_PERIOD_0 + 3), 16'd1000);
    write_reg(uer_pkg::REG_COUNT, 16'hFFFF);
    write_reg(uer_pkg::REG_ENABLE, 16'hFFFF);
    finish_writes();
    pending_ticks = {4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'h0, 4'h5, 4'hA, 4'h5, 4'hA, 4'h0};
    drain();

    write_reg(uer_pkg::CFG_IDX_W'(uer_pkg::REG_PERIOD_0 + 2), 16'd60000);
    write_reg(uer_pkg::REG_COUNT, 16'h0000);
    finish_writes();
    pending_ticks = {4'h0, 4'hF};
    drain();

    write_reg(uer_pkg::REG_COUNT, 16'h0003);
    finish_writes();
    pending_ticks = {4'h0, 4'hF, 4'h0};
    drain();

    write_reg(uer_pkg::REG_ENABLE, 16'h0006);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h0001);
    write_reg(uer_pkg::REG_COUNT, 16'h0002);
    finish_writes();
    pending_ticks = {4'hF, 4'h0, 4'hF};
    drain();

    configure(4'hF, 3'd4, 0, 40);
    queue_ticks(250);
    drain();

    idle_pct = 82;
    configure(4'hF, 3'd5, 0, 30);
    queue_ticks(180);
    drain();

    // hold the result side off while ticks keep coming
    idle_pct = 0;
    stall_pct = 82;
    configure(4'hF, 3'd4, 1, 25);
    hold_req = 1'b1;
    queue_ticks(200);
    drain();

    idle_pct = 32;
    stall_pct = 32;
    configure(4'($urandom), 3'($urandom_range(7)), 0, 60);
    queue_ticks(200);
    drain();

    configure(4'hF, 3'd4, 59990, 65535);
    queue_ticks(80);
    drain();

    idle_pct = 0;
    stall_pct = 0;
    configure(4'hF, 3'd1, 0, 5);
    queue_ticks(50);
    drain();

    repeat (5) @(posedge clk);
    $display("Checked %0d tick results over %0d register settings", ticks_checked, settings_count);
    $display("Triggers %0d, widths latched %0d, mismatches %0d",
             trigger_count, latch_count, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== ultrasonic_echo_ranger_core.f =====
+incdir+hw/rtl
hw/rtl/uer_pkg.sv
hw/rtl/uer_stream_if.sv
hw/rtl/uer_lane.sv
hw/rtl/uer_merge.sv
hw/rtl/ultrasonic_echo_ranger_core.sv
hw/rtl/uer_checker.sv
sim/tb_ultrasonic_echo_ranger_core.sv
